// File: hdl/wf3_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package wf3_pkg;

   localparam int WindowSize = 3;
   localparam int Taps       = WindowSize * WindowSize;
   localparam int PixWidth   = 8;
   localparam int ModeWidth  = 2;

   // filter_mode codes
   localparam logic [ModeWidth-1:0] MODE_EMBOSS  = 2'd0;
   localparam logic [ModeWidth-1:0] MODE_SHARPEN = 2'd1;
   localparam logic [ModeWidth-1:0] MODE_SOBEL   = 2'd2;
   localparam logic [ModeWidth-1:0] MODE_HOMOG   = 2'd3;

   localparam logic [PixWidth-1:0] EMBOSS_BIAS = 8'd128;
   localparam logic [PixWidth-1:0] HOMOG_BIAS  = 8'd60;

   typedef logic [PixWidth-1:0]  pix_type;
   typedef logic [ModeWidth-1:0] mode_type;

   // window in row-major order, index 0 is top-left
   typedef pix_type [Taps-1:0] window_type;

   // clamp a signed intermediate to 0..255
   function automatic pix_type clip14(input logic signed [13:0] v);
      pix_type r;
      if (v < 14'sd0) begin
         r = '0;
      end else if (v > 14'sd255) begin
         r = 8'hFF;
      end else begin
         r = v[7:0];
      end
      return r;
   endfunction

endpackage

`default_nettype wire

// File: hdl/wf3_filter.sv
`timescale 1ns / 1ps
`default_nettype none

module wf3_filter
   import wf3_pkg::*;
(
   input  wire window_type win,
   input  wire mode_type   mode,
   output pix_type         pixel
);

   logic signed [13:0] wx [Taps];
   logic signed [13:0] emb_diff;
   logic signed [13:0] sharp_acc;
   logic signed [13:0] sob_v;
   logic signed [13:0] sob_h;
   logic        [8:0]  emb_sum;
   logic        [8:0]  sob_sum;
   logic        [8:0]  hom_sum;
   pix_type            emb_clip;
   pix_type            sob_v_clip;
   pix_type            sob_h_clip;
   pix_type            hom_max;
   pix_type            hom_diff [Taps];
   pix_type            emb_px;
   pix_type            sharp_px;
   pix_type            sob_px;
   pix_type            hom_px;

   always_comb begin
      for (int i = 0; i < Taps; i++) begin
         wx[i] = signed'({6'd0, win[i]});
      end
   end

   // emboss: bottom-right minus top-left, clip, bias, clip
   assign emb_diff = wx[8] - wx[0];
   assign emb_clip = clip14(emb_diff);
   assign emb_sum  = {1'b0, emb_clip} + {1'b0, EMBOSS_BIAS};
   assign emb_px   = emb_sum[8] ? 8'hFF : emb_sum[7:0];

   // sharpen: 9*center minus the eight neighbors
   assign sharp_acc = (wx[4] <<< 3) + wx[4]
                    - (wx[0] + wx[1] + wx[2] + wx[3])
                    - (wx[5] + wx[6] + wx[7] + wx[8]);
   assign sharp_px  = clip14(sharp_acc);

   // sobel: left column minus right column, bottom row minus top row
   assign sob_v = (wx[0] + (wx[3] <<< 1) + wx[6]) - (wx[2] + (wx[5] <<< 1) + wx[8]);
   assign sob_h = (wx[6] + (wx[7] <<< 1) + wx[8]) - (wx[0] + (wx[1] <<< 1) + wx[2]);
   assign sob_v_clip = clip14(sob_v);
   assign sob_h_clip = clip14(sob_h);
   assign sob_sum    = {1'b0, sob_v_clip} + {1'b0, sob_h_clip};
   assign sob_px     = sob_sum[8] ? 8'hFF : sob_sum[7:0];

   // homogeneity: largest |center - pixel|, plus bias, saturated
   always_comb begin
      hom_max = '0;
      for (int i = 0; i < Taps; i++) begin
         hom_diff[i] = (win[4] >= win[i]) ? (win[4] - win[i]) : (win[i] - win[4]);
         if (hom_diff[i] > hom_max) begin
            hom_max = hom_diff[i];
         end
      end
   end
   assign hom_sum = {1'b0, hom_max} + {1'b0, HOMOG_BIAS};
   assign hom_px  = hom_sum[8] ? 8'hFF : hom_sum[7:0];

   always_comb begin
      unique case (mode)
         MODE_EMBOSS:  pixel = emb_px;
         MODE_SHARPEN: pixel = sharp_px;
         MODE_SOBEL:   pixel = sob_px;
         MODE_HOMOG:   pixel = hom_px;
         default:      pixel = emb_px;
      endcase
   end

endmodule

`default_nettype wire

// File: hdl/window_filter_3x3_core.sv
`timescale 1ns / 1ps
`default_nettype none

// 3x3 window filter core.
// Request channel (req_*): one 3x3 window of 8-bit pixels per request, packed
// row-major into req_tdata with the top-left pixel in bits [7:0] and the
// bottom-right pixel in bits [71:64].
// Response channel (rsp_*): one filtered 8-bit pixel per request, in order.
// csr_wr_en / csr_wr_data write filter_mode (0 emboss, 1 sharpen, 2 sobel,
// 3 homogeneity); write it only while no request is in flight.
// A request passes through the input register and then the result register,
// with the filter arithmetic between them, before rsp_tvalid rises.
// Throughput: one request per clock while the response side keeps up; the
// two register stages advance together, so the limit is the single result
// register drained once per cycle.
// Reset (synchronous, active high) empties both stages and sets filter_mode
// to emboss.
// When the receiver stalls, the response holds and both stages stay full;
// req_tready drops once the input stage has a request waiting behind it.
module window_filter_3x3_core
   import wf3_pkg::*;
(
   input  wire        clock,
   input  wire        reset,
   // req_tdata: pix_top_left, pix_top_mid, pix_top_right, pix_mid_left,
   // pix_center, pix_mid_right, pix_bot_left, pix_bot_mid, pix_bot_right
   input  wire        req_tvalid,
   output logic       req_tready,
   input  wire [71:0] req_tdata,
   // rsp_tdata: out_pixel
   output logic       rsp_tvalid,
   input  wire        rsp_tready,
   output logic [7:0] rsp_tdata,
   input  wire        csr_wr_en,
   input  wire [1:0]  csr_wr_data
);

   mode_type   mode_ff;
   logic       s1_valid_ff;
   window_type s1_win_ff;
   logic       rsp_valid_ff;
   pix_type    rsp_pixel_ff;
   pix_type    pixel_in;
   logic       advance;

   // both stages move together whenever the result register can take a value
   assign advance    = !rsp_valid_ff || rsp_tready;
   assign req_tready = advance || !s1_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_EMBOSS;
      end else if (csr_wr_en) begin
         mode_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_tready) begin
         s1_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         s1_win_ff <= req_tdata;
      end
   end

   wf3_filter u_filter (
      .win   (s1_win_ff),
      .mode  (mode_ff),
      .pixel (pixel_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && s1_valid_ff) begin
         rsp_pixel_ff <= pixel_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_pixel_ff;

`ifndef SYNTHESIS
   a_accept_fills_s1 : assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> s1_valid_ff)
      else $error("accepted request did not reach input stage");

   a_s1_moves_out : assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && advance |=> rsp_valid_ff)
      else $error("input stage advanced without producing a response");

   a_ready_when_empty : assert property (@(posedge clock) disable iff (reset)
      !s1_valid_ff |-> req_tready)
      else $error("empty input stage refused a request");

   a_rsp_drops_on_take : assert property (@(posedge clock) disable iff (reset)
      $fell(rsp_valid_ff) && !$past(reset) |-> $past(rsp_tready) && !$past(s1_valid_ff))
      else $error("response lost without being taken");
`endif

endmodule

`default_nettype wire
